FILE: rtl/lcsw_pkg.sv
// Package for the cache set: sizes, request codes, result type and address helpers.
package lcsw_pkg;

	localparam int WAYS      = 4;
	localparam int ADDR_BITS = 32;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W     = WAY_W;

	// request codes; the unused code is served as a read
	localparam logic [1:0] REQ_READ        = 2'd0;
	localparam logic [1:0] REQ_WRITE       = 2'd1;
	localparam logic [1:0] REQ_DIRTY_WRITE = 2'd2;

	typedef logic [AGE_W-1:0]     age_t;
	typedef logic [WAY_W-1:0]     way_t;
	typedef logic [ADDR_BITS-1:0] line_addr_t;

	typedef struct packed {
		logic        hit;
		logic        dirty_evict;
		logic [31:0] evict_address;
	} result_t;

	// 32-bit block address into the stored width (truncate or zero-extend)
	function automatic line_addr_t to_line_addr(input logic [31:0] a);
		line_addr_t r;
		r = '0;
		for (int i = 0; i < ADDR_BITS && i < 32; i++) begin
			r[i] = a[i];
		end
		return r;
	endfunction

	// low 32 bits of a stored address
	function automatic logic [31:0] to_evict_addr(input line_addr_t a);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < ADDR_BITS && i < 32; i++) begin
			r[i] = a[i];
		end
		return r;
	endfunction

endpackage

FILE: rtl/lcsw_set.sv
// Way storage of the set with lookup, victim choice and LRU age update.
module lcsw_set (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [1:0]             req_type,
	input  logic [31:0]            tag_in,
	input  logic [31:0]            block_address,
	output lcsw_pkg::result_t      result
);
	import lcsw_pkg::*;

	logic             valid_q [WAYS];
	logic             dirty_q [WAYS];
	age_t             age_q   [WAYS];
	logic [31:0]      tag_q   [WAYS];
	line_addr_t       addr_q  [WAYS];

	logic  hit;
	way_t  hit_way;
	way_t  victim_way;
	way_t  sel;
	age_t  thresh;
	logic  is_write;
	logic  evict;
	logic  new_dirty;

	// tag match (highest matching way wins) and victim (the oldest way)
	always_comb begin
		hit        = 1'b0;
		hit_way    = '0;
		victim_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (valid_q[w] && tag_q[w] == tag_in) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		// ages are a permutation, so exactly one way holds the top age
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (age_q[w] == AGE_W'(WAYS - 1)) begin
				victim_way = WAY_W'(w);
			end
		end
	end

	assign sel      = hit ? hit_way : victim_way;
	assign thresh   = age_q[sel];
	assign is_write = (req_type == REQ_WRITE) || (req_type == REQ_DIRTY_WRITE);
	assign evict    = !hit && valid_q[sel] && dirty_q[sel];
	assign new_dirty = is_write || (hit && dirty_q[sel]);

	assign result.hit           = hit;
	assign result.dirty_evict   = evict;
	assign result.evict_address = evict ? to_evict_addr(addr_q[sel]) : 32'd0;

	// control state: valid, dirty, ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WAYS; w++) begin
				valid_q[w] <= 1'b0;
				dirty_q[w] <= 1'b0;
				age_q[w]   <= AGE_W'(w);
			end
		end else if (en) begin
			for (int w = 0; w < WAYS; w++) begin
				if (WAY_W'(w) == sel) begin
					valid_q[w] <= 1'b1;
					dirty_q[w] <= new_dirty;
					age_q[w]   <= '0;
				end else if (age_q[w] < thresh) begin
					age_q[w] <= age_q[w] + 1'b1;
				end
			end
		end
	end

	// line payload: tag and address of the chosen way
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[sel]  <= tag_in;
			addr_q[sel] <= to_line_addr(block_address);
		end
	end

endmodule

FILE: rtl/lru_cache_set_writeback_unit.sv
// Top level of the write-back cache set with true LRU replacement.
// Usage:
//   Requests (req_type, tag_in, block_address) enter on req_valid/req_ready.
//   Each request gives exactly one response (hit, dirty_evict, evict_address)
//   on rsp_valid/rsp_ready, in request order.
//   A request taken into the request register is looked up there; its
//   response enters the response register once that is free or drained.
//   Throughput: one request per cycle while responses are taken; tag compare,
//   victim pick and age update are combinational between the two registers.
//   A stalled response (rsp_ready low) holds in the response register; an
//   empty request register still takes one more request, then req_ready
//   stays low until the response is taken.
//   Reset (arst_n low) empties both registers, clears valid and dirty bits
//   and sets each way's age to its own index; no request is lost or
//   repeated across a stall.
module lru_cache_set_writeback_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] tag_in,
	input  logic [31:0] block_address,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        hit,
	output logic        dirty_evict,
	output logic [31:0] evict_address
);
	import lcsw_pkg::*;

	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [31:0] tag_s1;
	logic [31:0] addr_s1;
	logic        rsp_valid_q;
	result_t     rsp_q;
	result_t     res;
	logic        advance;

	// lookup fires when the response register is free or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_s1 <= req_type;
			tag_s1      <= tag_in;
			addr_s1     <= block_address;
		end
	end

	lcsw_set u_set (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.req_type      (req_type_s1),
		.tag_in        (tag_s1),
		.block_address (addr_s1),
		.result        (res)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign hit           = rsp_q.hit;
	assign dirty_evict   = rsp_q.dirty_evict;
	assign evict_address = rsp_q.evict_address;

endmodule

FILE: rtl/lcsw_checker.sv
// Port-level checks for the cache set, bound to the top level.
module lcsw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] tag_in,
	input  logic [31:0] block_address,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic        hit,
	input  logic        dirty_evict,
	input  logic [31:0] evict_address
);

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> !dirty_evict)
		else $error("response shows both hit and dirty eviction");

	// evict address is zero unless a dirty line left
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !dirty_evict |-> evict_address == 32'd0)
		else $error("evict address nonzero without dirty eviction");

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

endmodule

bind lru_cache_set_writeback_unit lcsw_checker u_lcsw_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for the write-back LRU cache set: random and directed requests, checked responses.
module testbench;
	import lcsw_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_REQS  = 1130;
	localparam int LONG_HOLD_AT = 400;
	localparam int LONG_HOLD    = 60;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE       = 8;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] tag;
		logic [31:0] addr;
		bit          drain;
	} req_item_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        req_valid     = 1'b0;
	logic        req_ready;
	logic [1:0]  req_type      = REQ_READ;
	logic [31:0] tag_in        = '0;
	logic [31:0] block_address = '0;
	logic        rsp_valid;
	logic        rsp_ready     = 1'b0;
	logic        hit;
	logic        dirty_evict;
	logic [31:0] evict_address;

	// shadow copy of the set
	logic       way_valid [WAYS];
	logic       way_dirty [WAYS];
	logic [31:0] way_tag  [WAYS];
	line_addr_t way_addr  [WAYS];
	age_t       way_age   [WAYS];

	req_item_t pending_reqs[$];
	result_t   awaiting_rsp[$];

	int sent_cnt     = 0;
	int received_cnt = 0;
	int hit_cnt      = 0;
	int writeback_cnt = 0;
	int errors       = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	int idle_cycles  = 0;

	lru_cache_set_writeback_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.tag_in(tag_in),
		.block_address(block_address),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.hit(hit),
		.dirty_evict(dirty_evict),
		.evict_address(evict_address)
	);

	always #10 clk = ~clk;

	// lookup, victim pick, write-back report and LRU update for one request
	function automatic result_t cache_access(input logic [1:0] kind, input logic [31:0] tag,
			input logic [31:0] addr);
		result_t r;
		bit found;
		int sel;
		int victim;
		age_t thresh;
		bit dirtying;
		r = '0;
		found = 1'b0;
		sel = 0;
		victim = 0;
		dirtying = (kind == REQ_WRITE) || (kind == REQ_DIRTY_WRITE);
		for (int w = 0; w < WAYS; w++) begin
			if (way_valid[w] && way_tag[w] == tag) begin
				found = 1'b1;
				sel = w;
			end
			if (way_age[w] > way_age[victim]) begin
				victim = w;
			end
		end
		// miss: refill the oldest way, writing back its line if dirty
		if (!found) begin
			sel = victim;
			if (way_valid[sel] && way_dirty[sel]) begin
				r.dirty_evict = 1'b1;
				r.evict_address = way_addr[sel];
			end
			way_dirty[sel] = 1'b0;
		end
		thresh = way_age[sel];
		for (int w = 0; w < WAYS; w++) begin
			if (way_age[w] < thresh) begin
				way_age[w] = way_age[w] + 1'b1;
			end
		end
		way_age[sel] = '0;
		way_addr[sel] = addr;
		way_tag[sel] = tag;
		way_valid[sel] = 1'b1;
		if (dirtying) begin
			way_dirty[sel] = 1'b1;
		end
		r.hit = found;
		return r;
	endfunction

	function automatic void add_req(input logic [1:0] kind, input logic [31:0] tag,
			input logic [31:0] addr);
		req_item_t it;
		it.kind = kind;
		it.tag = tag;
		it.addr = addr;
		it.drain = 1'b0;
		pending_reqs.push_back(it);
	endfunction

	// marker: sender holds off until every response is back
	function automatic void add_drain();
		req_item_t it;
		it.kind = REQ_READ;
		it.tag = '0;
		it.addr = '0;
		it.drain = 1'b1;
		pending_reqs.push_back(it);
	endfunction

	// per-item wait; calm stretches have none, busy ones mostly short with some long
	function automatic int draw_wait(input bit calm);
		if (calm) begin
			return 0;
		end
		if ($urandom_range(0, 2) == 0) begin
			return $urandom_range(0, 17);
		end
		return $urandom_range(0, 2);
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("ERROR (response %0d): %s", received_cnt, msg);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		int nxt_gap;
		req_item_t it;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_type <= REQ_READ;
			tag_in <= '0;
			block_address <= '0;
			gap_left <= 0;
		end else begin
			nxt_gap = gap_left;
			if (req_valid && req_ready) begin
				awaiting_rsp.push_back(cache_access(req_type, tag_in, block_address));
				sent_cnt++;
				nxt_gap = draw_wait(((sent_cnt / 128) % 4) == 1);
			end
			if (req_valid && !req_ready) begin
				// hold the offered request
			end else if (nxt_gap > 0) begin
				req_valid <= 1'b0;
				gap_left <= nxt_gap - 1;
			end else if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
				req_valid <= 1'b0;
				gap_left <= 0;
				if (awaiting_rsp.size() == 0) begin
					void'(pending_reqs.pop_front());
				end
			end else if (pending_reqs.size() != 0) begin
				it = pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_type <= it.kind;
				tag_in <= it.tag;
				block_address <= it.addr;
				gap_left <= 0;
			end else begin
				req_valid <= 1'b0;
				gap_left <= 0;
			end
		end
	end

	// response monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		int nxt_stall;
		result_t exp_r;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			nxt_stall = stall_left;
			if (rsp_valid && rsp_ready) begin
				if (awaiting_rsp.size() == 0) begin
					note_failure($sformatf("unexpected response hit=%0b dirty_evict=%0b addr=%08h",
						hit, dirty_evict, evict_address));
				end else begin
					exp_r = awaiting_rsp.pop_front();
					if (hit !== exp_r.hit) begin
						note_failure($sformatf("hit: expected %0b, got %0b", exp_r.hit, hit));
					end
					if (dirty_evict !== exp_r.dirty_evict) begin
						note_failure($sformatf("dirty_evict: expected %0b, got %0b",
							exp_r.dirty_evict, dirty_evict));
					end
					if (evict_address !== exp_r.evict_address) begin
						note_failure($sformatf("evict_address: expected %08h, got %08h",
							exp_r.evict_address, evict_address));
					end
					if (exp_r.hit) begin
						hit_cnt++;
					end
					if (exp_r.dirty_evict) begin
						writeback_cnt++;
					end
				end
				received_cnt++;
				nxt_stall = draw_wait(((received_cnt / 128) % 4) == 2);
				// one long hold so the unit backs up and stalls requests
				if (received_cnt == LONG_HOLD_AT) begin
					nxt_stall = LONG_HOLD;
				end
			end
			if (nxt_stall > 0) begin
				rsp_ready <= 1'b0;
				stall_left <= nxt_stall - 1;
			end else begin
				rsp_ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("Timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus and end of run
	initial begin
		logic [31:0] tag_pool [8];
		int pool_n;
		int pick;
		logic [1:0] kind;
		logic [31:0] t;
		logic [31:0] a;

		for (int w = 0; w < WAYS; w++) begin
			way_valid[w] = 1'b0;
			way_dirty[w] = 1'b0;
			way_tag[w] = '0;
			way_addr[w] = '0;
			way_age[w] = age_t'(w);
		end

		// directed: fills, every request kind, hits on dirty and clean lines,
		// code 3 as a read, address replaced on a hit, clean and dirty victims
		add_req(REQ_READ, 32'h0000_0000, 32'h0000_0000);
		add_req(REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(REQ_DIRTY_WRITE, 32'h1234_5678, 32'h8000_0001);
		add_req(REQ_UNUSED, 32'h0000_0002, 32'hA5A5_A5A5);
		add_req(REQ_READ, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		add_req(REQ_WRITE, 32'h0000_0000, 32'h0000_0001);
		add_req(REQ_DIRTY_WRITE, 32'h0000_0002, 32'h0F0F_0F0F);
		add_req(REQ_READ, 32'hAAAA_5555, 32'hFFFF_0000);
		add_req(REQ_READ, 32'h5555_AAAA, 32'h0000_FFFF);
		add_req(REQ_READ, 32'h8000_0000, 32'h7FFF_FFFF);
		add_req(REQ_READ, 32'h0000_0001, 32'hC3C3_3C3C);
		add_req(REQ_READ, 32'hAAAA_5555, 32'h1111_1111);
		add_req(REQ_WRITE, 32'h5555_AAAA, 32'h2222_2222);
		add_req(REQ_UNUSED, 32'h7FFF_FFFF, 32'h3333_3333);
		add_req(REQ_READ, 32'h0000_0003, 32'h4444_4444);
		add_req(REQ_READ, 32'h0000_0004, 32'h5555_5555);
		add_req(REQ_READ, 32'h0000_0005, 32'h6666_6666);
		add_req(REQ_DIRTY_WRITE, 32'h0000_0003, 32'hFFFF_FFFE);
		add_req(REQ_READ, 32'h0000_0006, 32'h0000_0000);
		add_req(REQ_READ, 32'h0000_0007, 32'h0000_0000);
		add_drain();

		// random: small tag pools for hit/evict churn, plus stray and extreme tags
		pool_n = 2;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 64 == 0) begin
				pool_n = $urandom_range(2, 8);
				for (int j = 0; j < 8; j++) begin
					tag_pool[j] = $urandom;
				end
			end
			if (i == RANDOM_REQS / 2) begin
				add_drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				t = tag_pool[$urandom_range(0, pool_n - 1)];
			end else if (pick < 80) begin
				t = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
			end else begin
				t = $urandom;
			end
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				kind = REQ_READ;
			end else if (pick < 7) begin
				kind = REQ_WRITE;
			end else if (pick < 9) begin
				kind = REQ_DIRTY_WRITE;
			end else begin
				kind = REQ_UNUSED;
			end
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				a = 32'h0000_0000;
			end else if (pick == 1) begin
				a = 32'hFFFF_FFFF;
			end else begin
				a = $urandom;
			end
			add_req(kind, t, a);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid || awaiting_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);

		$display("Run covered %0d requests and %0d responses: %0d hits, %0d dirty write-backs,",
			sent_cnt, received_cnt, hit_cnt, writeback_cnt);
		$display("with random gaps on both sides, one long response hold and two full drains.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
